/* rtl/avgp_pkg.sv */
// Shared constants, register indexes and types for the average pooling block.
package avgp_pkg;

  // Default sizing
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_WINDOW  = 8;
  localparam int SAMPLE_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 11;
  localparam int WINDOW_SIZE_W = 4;
  localparam int PLANE_DIM_W   = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 2'd2;

  localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RST  = 4'd2;
  localparam logic [PLANE_DIM_W-1:0]   PLANE_WIDTH_RST  = 11'd1024;
  localparam logic [PLANE_DIM_W-1:0]   PLANE_HEIGHT_RST = 11'd1024;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Window position of one in-region sample
  typedef struct packed {
    logic col_first;  // first column of its window
    logic col_last;   // last column of its window
    logic row_first;  // first row of its window
    logic row_last;   // last row of its window
    logic last_col;   // window is the last one of its output row
    logic last_row;   // window lies in the last output row
  } pos_flags_t;

endpackage

/* rtl/average_pool_forward.sv */
// Top level of the non-overlapping k-by-k average pooling block.
//
// Usage
//   Samples (signed Q8.8) enter on the s_axis channel in raster order, one plane
//   after another. Each full k-by-k window yields one mean on the m_axis channel,
//   truncated toward zero; tuser flags the last mean of an output row, tlast the
//   last mean of the plane. Trailing rows/columns that do not fill a window are
//   consumed and give nothing.
//   Registers (window_size, plane_width, plane_height) are written through
//   cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle; a write to any of them restarts
//   the stream at the top of a plane.
// Timing
//   One sample per clock sustained while m_axis_tready stays high. The front end
//   counts positions and pushes into a 4-entry queue; the back end adds the sample
//   into the window sum, merges the column sum read from a MAX_WIDTH-entry memory,
//   then divides by k*k with a reciprocal multiply. After the window's last sample
//   the mean passes the accumulate, magnitude, multiply and output registers.
// Reset and stall
//   Reset loads window 2 and a 1024x1024 plane and clears all positions; the
//   column sum memory needs no clearing since each entry is written on the first
//   row of a window before it is read. When m_axis_tready is low the pipeline
//   and queue fill, after which s_axis_tready drops; nothing is lost.
module average_pool_forward #(
  parameter int MAX_WIDTH   = avgp_pkg::MAX_WIDTH,
  parameter int MAX_WINDOW  = avgp_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS = avgp_pkg::SAMPLE_BITS,
  localparam int TdataW     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [avgp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [avgp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TdataW-1:0]               s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TdataW-1:0]               m_axis_tdata,   // [SAMPLE_BITS-1:0] average
  output logic                            m_axis_tuser,   // row_end
  output logic                            m_axis_tlast    // plane_end
);

  localparam int IdxW  = $clog2(MAX_WIDTH);
  localparam int KW    = $clog2(MAX_WINDOW + 1);
  localparam int FlagW = $bits(avgp_pkg::pos_flags_t);
  localparam int ItemW = SAMPLE_BITS + FlagW + IdxW;

  logic                   push, queue_full, queue_valid, pop;
  logic [SAMPLE_BITS-1:0] push_sample, pop_sample, out_average;
  logic [IdxW-1:0]        push_wc, pop_wc;
  avgp_pkg::pos_flags_t   push_flags, pop_flags;
  logic [KW-1:0]          win_k;
  logic [ItemW-1:0]       push_item, pop_item;

  avgp_front #(
    .MaxWidth   (MAX_WIDTH),
    .MaxWindow  (MAX_WINDOW),
    .SampleBits (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_sample_o (push_sample),
    .push_wc_o     (push_wc),
    .push_flags_o  (push_flags),
    .win_k_o       (win_k)
  );

  // Queue entry: sample in the low bits, then flags, then window column
  assign push_item = {push_wc, push_flags, push_sample};

  avgp_queue #(
    .DataW (ItemW),
    .Depth (avgp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .data_o      (pop_item)
  );

  assign pop_sample = pop_item[SAMPLE_BITS-1:0];
  assign pop_flags  = pop_item[SAMPLE_BITS +: FlagW];
  assign pop_wc     = pop_item[SAMPLE_BITS + FlagW +: IdxW];

  avgp_back #(
    .MaxWidth   (MAX_WIDTH),
    .MaxWindow  (MAX_WINDOW),
    .SampleBits (SAMPLE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .win_k_i         (win_k),
    .item_valid_i    (queue_valid),
    .item_pop_o      (pop),
    .item_sample_i   (pop_sample),
    .item_wc_i       (pop_wc),
    .item_flags_i    (pop_flags),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_average_o   (out_average),
    .out_row_end_o   (m_axis_tuser),
    .out_plane_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = TdataW'(out_average);

endmodule

/* rtl/avgp_front.sv */
// Front end: config registers, raster position counters and window classification.
module avgp_front #(
  parameter int MaxWidth   = avgp_pkg::MAX_WIDTH,
  parameter int MaxWindow  = avgp_pkg::MAX_WINDOW,
  parameter int SampleBits = avgp_pkg::SAMPLE_BITS,
  localparam int IdxW      = $clog2(MaxWidth),
  localparam int KW        = $clog2(MaxWindow + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [avgp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [avgp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SampleBits-1:0]             in_sample_i,
  input  logic                              queue_full_i,
  output logic                              push_o,
  output logic [SampleBits-1:0]             push_sample_o,
  output logic [IdxW-1:0]                   push_wc_o,
  output avgp_pkg::pos_flags_t              push_flags_o,
  output logic [KW-1:0]                     win_k_o
);

  localparam int PosW  = $clog2(MaxWidth);
  localparam int OffW  = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int DimW  = $clog2(MaxWidth + 1);
  localparam int SumW  = DimW + 2;
  localparam int KExtW = (KW > avgp_pkg::WINDOW_SIZE_W) ? KW : avgp_pkg::WINDOW_SIZE_W;
  localparam int DExtW = (DimW > avgp_pkg::PLANE_DIM_W) ? DimW : avgp_pkg::PLANE_DIM_W;

  logic [avgp_pkg::WINDOW_SIZE_W-1:0] win_size_q;
  logic [avgp_pkg::PLANE_DIM_W-1:0]   plane_w_q, plane_h_q;

  logic [KW-1:0]   k_eff;
  logic [DimW-1:0] w_eff, h_eff;

  logic [PosW-1:0] col_pos_q, col_pos_d, row_pos_q, row_pos_d;
  logic [PosW-1:0] col_start_q, col_start_d, row_start_q, row_start_d;
  logic [OffW-1:0] col_off_q, col_off_d, row_off_q, row_off_d;
  logic [IdxW-1:0] wc_q, wc_d;

  logic accept, restart, in_region, row_done, plane_done, col_wrap, row_wrap;
  avgp_pkg::pos_flags_t flags;

  // Register clamping: zero reads as one, oversize saturates
  always_comb begin
    if (win_size_q == '0) begin
      k_eff = KW'(1);
    end else if (KExtW'(win_size_q) > KExtW'(MaxWindow)) begin
      k_eff = KW'(MaxWindow);
    end else begin
      k_eff = KW'(win_size_q);
    end
    if (plane_w_q == '0) begin
      w_eff = DimW'(1);
    end else if (DExtW'(plane_w_q) > DExtW'(MaxWidth)) begin
      w_eff = DimW'(MaxWidth);
    end else begin
      w_eff = DimW'(plane_w_q);
    end
    if (plane_h_q == '0) begin
      h_eff = DimW'(1);
    end else if (DExtW'(plane_h_q) > DExtW'(MaxWidth)) begin
      h_eff = DimW'(MaxWidth);
    end else begin
      h_eff = DimW'(plane_h_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= avgp_pkg::WINDOW_SIZE_RST;
      plane_w_q  <= avgp_pkg::PLANE_WIDTH_RST;
      plane_h_q  <= avgp_pkg::PLANE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        avgp_pkg::CFG_WINDOW_SIZE:  win_size_q <= cfg_data_i[avgp_pkg::WINDOW_SIZE_W-1:0];
        avgp_pkg::CFG_PLANE_WIDTH:  plane_w_q  <= cfg_data_i[avgp_pkg::PLANE_DIM_W-1:0];
        avgp_pkg::CFG_PLANE_HEIGHT: plane_h_q  <= cfg_data_i[avgp_pkg::PLANE_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i == avgp_pkg::CFG_WINDOW_SIZE ||
                                cfg_idx_i == avgp_pkg::CFG_PLANE_WIDTH ||
                                cfg_idx_i == avgp_pkg::CFG_PLANE_HEIGHT);

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classification of the current sample
  assign col_wrap   = (KW'(col_off_q) == k_eff - KW'(1));
  assign row_wrap   = (KW'(row_off_q) == k_eff - KW'(1));
  assign row_done   = (DimW'(col_pos_q) == w_eff - DimW'(1));
  assign plane_done = (DimW'(row_pos_q) == h_eff - DimW'(1));

  assign in_region = (SumW'(col_start_q) + SumW'(k_eff) <= SumW'(w_eff)) &&
                     (SumW'(row_start_q) + SumW'(k_eff) <= SumW'(h_eff));

  always_comb begin
    flags.col_first = (col_off_q == '0);
    flags.col_last  = col_wrap;
    flags.row_first = (row_off_q == '0);
    flags.row_last  = row_wrap;
    flags.last_col  = SumW'(col_start_q) + SumW'(k_eff) + SumW'(k_eff) > SumW'(w_eff);
    flags.last_row  = SumW'(row_start_q) + SumW'(k_eff) + SumW'(k_eff) > SumW'(h_eff);
  end

  // Position update
  always_comb begin
    col_pos_d   = col_pos_q;
    col_off_d   = col_off_q;
    col_start_d = col_start_q;
    wc_d        = wc_q;
    row_pos_d   = row_pos_q;
    row_off_d   = row_off_q;
    row_start_d = row_start_q;
    if (accept) begin
      if (row_done) begin
        col_pos_d   = '0;
        col_off_d   = '0;
        col_start_d = '0;
        wc_d        = '0;
        if (plane_done) begin
          row_pos_d   = '0;
          row_off_d   = '0;
          row_start_d = '0;
        end else begin
          row_pos_d = row_pos_q + PosW'(1);
          if (row_wrap) begin
            row_off_d   = '0;
            row_start_d = row_pos_q + PosW'(1);
          end else begin
            row_off_d = row_off_q + OffW'(1);
          end
        end
      end else begin
        col_pos_d = col_pos_q + PosW'(1);
        if (col_wrap) begin
          col_off_d   = '0;
          col_start_d = col_pos_q + PosW'(1);
          wc_d        = wc_q + IdxW'(1);
        end else begin
          col_off_d = col_off_q + OffW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q   <= '0;
      col_off_q   <= '0;
      col_start_q <= '0;
      wc_q        <= '0;
      row_pos_q   <= '0;
      row_off_q   <= '0;
      row_start_q <= '0;
    end else if (restart) begin
      col_pos_q   <= '0;
      col_off_q   <= '0;
      col_start_q <= '0;
      wc_q        <= '0;
      row_pos_q   <= '0;
      row_off_q   <= '0;
      row_start_q <= '0;
    end else begin
      col_pos_q   <= col_pos_d;
      col_off_q   <= col_off_d;
      col_start_q <= col_start_d;
      wc_q        <= wc_d;
      row_pos_q   <= row_pos_d;
      row_off_q   <= row_off_d;
      row_start_q <= row_start_d;
    end
  end

  // Out-of-region samples are consumed here and never queued
  assign push_o        = accept && in_region;
  assign push_sample_o = in_sample_i;
  assign push_wc_o     = wc_q;
  assign push_flags_o  = flags;
  assign win_k_o       = k_eff;

endmodule

/* rtl/avgp_queue.sv */
// Small register FIFO between front end and back end.
module avgp_queue #(
  parameter int DataW = 8,
  parameter int Depth = avgp_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [DataW-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

/* rtl/avgp_back.sv */
// Back end: window accumulation, column sum memory, divide by area, output register.
module avgp_back #(
  parameter int MaxWidth   = avgp_pkg::MAX_WIDTH,
  parameter int MaxWindow  = avgp_pkg::MAX_WINDOW,
  parameter int SampleBits = avgp_pkg::SAMPLE_BITS,
  localparam int IdxW      = $clog2(MaxWidth),
  localparam int KW        = $clog2(MaxWindow + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KW-1:0]        win_k_i,
  input  logic                 item_valid_i,
  output logic                 item_pop_o,
  input  logic [SampleBits-1:0] item_sample_i,
  input  logic [IdxW-1:0]      item_wc_i,
  input  avgp_pkg::pos_flags_t item_flags_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SampleBits-1:0] out_average_o,
  output logic                 out_row_end_o,
  output logic                 out_plane_end_o
);

  localparam int WL    = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int AccW  = SampleBits + 2 * WL;
  localparam int Shift = AccW + 2 * WL;
  localparam int RcpW  = Shift + 1;
  localparam int ProdW = AccW + RcpW;

  // Reciprocal of the window area, rounded up, indexed by k
  logic [RcpW-1:0] rcp_tab [MaxWindow + 1];
  assign rcp_tab[0] = '0;
  for (genvar g = 1; g <= MaxWindow; g++) begin : g_rcp
    localparam longint Area = longint'(g * g);
    localparam logic [RcpW-1:0] Rcp = RcpW'(((64'd1 << Shift) + Area - 64'd1) / Area);
    assign rcp_tab[g] = Rcp;
  end

  logic [AccW-1:0] col_mem [MaxWidth];
  logic [AccW-1:0] mem_rd_q;

  logic [AccW-1:0] run_sum_q, run_sum_d, sample_ext;

  // Accumulate stage
  logic                 b1_valid_q;
  logic [AccW-1:0]      b1_sum_q;
  logic [IdxW-1:0]      b1_wc_q;
  avgp_pkg::pos_flags_t b1_flags_q;
  logic [AccW-1:0]      b1_acc;
  logic                 b1_ready, b1_fire, b1_to_div, b1_store;

  // Magnitude stage
  logic            b2_valid_q, b2_neg_q, b2_last_col_q, b2_last_row_q, b2_ready;
  logic [AccW-1:0] b2_mag_q;
  logic [RcpW-1:0] b2_rcp_q;

  // Multiply stage
  logic             b3_valid_q, b3_neg_q, b3_last_col_q, b3_last_row_q, b3_ready;
  logic [ProdW-1:0] b3_prod_q;
  logic [SampleBits:0] quot;

  // Output register
  logic                  out_valid_q, out_row_end_q, out_plane_end_q, out_free;
  logic [SampleBits-1:0] out_avg_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign b3_ready = !b3_valid_q || out_free;
  assign b2_ready = !b2_valid_q || b3_ready;

  // Rows that do not finish a window leave without waiting on the divider
  assign b1_to_div  = b1_valid_q && b1_flags_q.row_last;
  assign b1_store   = b1_valid_q && !b1_flags_q.row_last;
  assign b1_ready   = !b1_valid_q || !b1_flags_q.row_last || b2_ready;
  assign b1_fire    = b1_valid_q && b1_ready;
  assign item_pop_o = item_valid_i && b1_ready;

  assign sample_ext = {{(AccW - SampleBits){item_sample_i[SampleBits-1]}}, item_sample_i};
  assign run_sum_d  = (item_flags_i.col_first ? '0 : run_sum_q) + sample_ext;
  assign b1_acc     = b1_sum_q + (b1_flags_q.row_first ? '0 : mem_rd_q);

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      run_sum_q  <= run_sum_d;
      b1_sum_q   <= run_sum_d;
      b1_wc_q    <= item_wc_i;
      b1_flags_q <= item_flags_i;
      mem_rd_q   <= col_mem[item_wc_i];
    end
    if (b1_store) begin
      col_mem[b1_wc_q] <= b1_acc;
    end
    if (b1_to_div && b2_ready) begin
      b2_neg_q      <= b1_acc[AccW-1];
      b2_mag_q      <= b1_acc[AccW-1] ? (~b1_acc + AccW'(1)) : b1_acc;
      b2_rcp_q      <= rcp_tab[win_k_i];
      b2_last_col_q <= b1_flags_q.last_col;
      b2_last_row_q <= b1_flags_q.last_row;
    end
    if (b2_valid_q && b3_ready) begin
      b3_prod_q     <= ProdW'(b2_mag_q) * ProdW'(b2_rcp_q);
      b3_neg_q      <= b2_neg_q;
      b3_last_col_q <= b2_last_col_q;
      b3_last_row_q <= b2_last_row_q;
    end
    if (b3_valid_q && out_free) begin
      out_avg_q       <= b3_neg_q ? SampleBits'(~quot + 1'b1) : SampleBits'(quot);
      out_row_end_q   <= b3_last_col_q;
      out_plane_end_q <= b3_last_col_q && b3_last_row_q;
    end
  end

  assign quot = b3_prod_q[Shift +: SampleBits + 1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_pop_o) begin
        b1_valid_q <= item_flags_i.col_last;
      end else if (b1_fire) begin
        b1_valid_q <= 1'b0;
      end
      if (b2_ready) begin
        b2_valid_q <= b1_to_div;
      end
      if (b3_ready) begin
        b3_valid_q <= b2_valid_q;
      end
      if (out_free) begin
        out_valid_q <= b3_valid_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_average_o   = out_avg_q;
  assign out_row_end_o   = out_row_end_q;
  assign out_plane_end_o = out_plane_end_q;

endmodule

/* dv/tb_top.sv */
// Self-checking stream testbench for the k-by-k average pooling block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import avgp_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 200;
  localparam int RANDOM_ITEMS  = 330;
  localparam int BIG_RUN       = 24;    // samples per saturated-geometry closing run

  // index with no register behind it; a write must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] avg;
    logic                   row_end;
    logic                   plane_end;
  } mean_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [SAMPLE_BITS-1:0] smp;
    bit                     typed;  // want holds a hand-written mean
    mean_t                  want;
  } stim_row_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // DUT-facing signals; the ones the bench drives are known from time zero
  logic                   cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   smp_valid = 1'b0;
  logic                   smp_ready;
  logic [SAMPLE_BITS-1:0] smp_data = '0;
  logic                   mean_valid;
  logic                   mean_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] mean_data;
  logic                   mean_row_end;
  logic                   mean_plane_end;

  average_pool_forward dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (smp_valid),
    .s_axis_tready (smp_ready),
    .s_axis_tdata  (smp_data),
    .m_axis_tvalid (mean_valid),
    .m_axis_tready (mean_ready),
    .m_axis_tdata  (mean_data),
    .m_axis_tuser  (mean_row_end),
    .m_axis_tlast  (mean_plane_end)
  );

  // ---------------------------------------------------------------------------
  // Pooling predictor: own copy of registers, positions and partial sums.
  // Column sums are never read before the first window row writes them.
  // ---------------------------------------------------------------------------
  logic [WINDOW_SIZE_W-1:0] pm_window = WINDOW_SIZE_RST;
  logic [PLANE_DIM_W-1:0]   pm_width  = PLANE_WIDTH_RST;
  logic [PLANE_DIM_W-1:0]   pm_height = PLANE_HEIGHT_RST;
  int pm_col_sums [MAX_WIDTH];
  int pm_col     = 0;
  int pm_row     = 0;
  int pm_win_col = 0;
  int pm_win_row = 0;
  int pm_seg_sum = 0;

  // zero reads as one, oversize saturates
  function automatic int clamp_dim(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void pool_set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WINDOW_SIZE:  pm_window = val[WINDOW_SIZE_W-1:0];
      CFG_PLANE_WIDTH:  pm_width  = val[PLANE_DIM_W-1:0];
      CFG_PLANE_HEIGHT: pm_height = val[PLANE_DIM_W-1:0];
      default:          return;  // unused index: no restart
    endcase
    pm_col     = 0;
    pm_row     = 0;
    pm_win_col = 0;
    pm_win_row = 0;
    pm_seg_sum = 0;
  endfunction

  function automatic bit pool_predict(logic [SAMPLE_BITS-1:0] smp, output mean_t res);
    int k, w, h, out_w, out_h, wc, acc, s;
    bit hit;
    k     = clamp_dim(int'(pm_window), MAX_WINDOW);
    w     = clamp_dim(int'(pm_width), MAX_WIDTH);
    h     = clamp_dim(int'(pm_height), MAX_WIDTH);
    out_w = w / k;
    out_h = h / k;
    s     = $signed(smp);
    hit   = 1'b0;
    res   = '0;
    // trailing partial columns and rows are swallowed
    if (pm_col < out_w * k && pm_row < out_h * k) begin
      wc = pm_col / k;
      if (pm_win_col == 0) pm_seg_sum = 0;
      pm_seg_sum += s;
      if (pm_win_col == k - 1) begin
        acc = pm_seg_sum;
        if (pm_win_row != 0) acc += pm_col_sums[wc];
        if (pm_win_row == k - 1) begin
          // int division truncates toward zero
          res.avg       = SAMPLE_BITS'(acc / (k * k));
          res.row_end   = (wc == out_w - 1);
          res.plane_end = (wc == out_w - 1) && (pm_row / k == out_h - 1);
          hit = 1'b1;
        end else begin
          pm_col_sums[wc] = acc;
        end
      end
    end
    pm_win_col = (pm_win_col + 1 >= k) ? 0 : pm_win_col + 1;
    pm_col++;
    if (pm_col >= w) begin
      pm_col     = 0;
      pm_win_col = 0;
      pm_win_row = (pm_win_row + 1 >= k) ? 0 : pm_win_row + 1;
      pm_row++;
      if (pm_row >= h) begin
        pm_row     = 0;
        pm_win_row = 0;
      end
    end
    return hit;
  endfunction

  mean_t pending_means[$];
  int    n_errors     = 0;
  bit    tx_calm      = 1'b0;
  bit    rx_calm      = 1'b0;
  bit    rx_long_hold = 1'b0;

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 15)) - 16'd8;  // near zero, both signs
      3:       return {1'b1, 15'($urandom())};
      default: return 16'($urandom());
    endcase
  endfunction

  // caller lowers cfg_we after the last write of a batch
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    pool_set_reg(idx, val);
  endtask

  // stop offering and wait for the block to go quiet
  task automatic settle();
    smp_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one sample transaction; gap (if any) goes in front so valid never dips and rises
  // in the same step
  task automatic send_sample(logic [SAMPLE_BITS-1:0] smp, bit typed, mean_t want);
    mean_t got;
    bit    hit;
    if (!tx_calm && $urandom_range(0, 4) == 0) begin
      smp_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    smp_valid <= 1'b1;
    smp_data  <= smp;
    @(posedge clk_i);
    while (!smp_ready) @(posedge clk_i);
    hit = pool_predict(smp, got);
    if (typed) pending_means.push_back(want);
    else if (hit) pending_means.push_back(got);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : rx_ready_gen
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_long_hold) begin
        mean_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_long_hold = 1'b0;
      end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
        mean_ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk_i);
      end else begin
        mean_ready <= 1'b1;
      end
    end
  end

  // mean checker: every accepted transaction against the oldest expectation
  always @(posedge clk_i) begin : check_means
    mean_t want;
    if (rst_ni && mean_valid && mean_ready) begin
      if (pending_means.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected mean: avg %h row_end %b plane_end %b",
                   mean_data, mean_row_end, mean_plane_end);
      end else begin
        want = pending_means.pop_front();
        if (mean_data !== want.avg || mean_row_end !== want.row_end ||
            mean_plane_end !== want.plane_end) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mean mismatch: exp avg %h row_end %b plane_end %b, got %h %b %b",
                     want.avg, want.row_end, want.plane_end,
                     mean_data, mean_row_end, mean_plane_end);
        end
      end
    end
  end

  // watchdog
  int cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("average_pool_forward regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic stim_row_t row_smp(logic [SAMPLE_BITS-1:0] smp);
    stim_row_t r;
    r = '{default: '0};
    r.smp = smp;
    return r;
  endfunction

  function automatic stim_row_t row_mean(logic [SAMPLE_BITS-1:0] smp, logic [SAMPLE_BITS-1:0] avg,
                                         logic row_end, logic plane_end);
    stim_row_t r;
    r = row_smp(smp);
    r.typed = 1'b1;
    r.want  = '{avg, row_end, plane_end};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    stim_row_t rows[$];
    logic [CFG_IDX_W-1:0] reg_order[3];
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
    mean_t none;
    bit in_cfg;
    int phase, n, kv, wv, hv, ke, we, he, start, rand_items;

    none = '0;
    reg_order = '{CFG_WINDOW_SIZE, CFG_PLANE_WIDTH, CFG_PLANE_HEIGHT};

    // reset geometry: first window row only, nothing comes out
    rows.push_back(row_smp(16'h1234));
    rows.push_back(row_smp(16'hEDCB));
    // zero window and zero dims all read as one: every sample is its own mean
    rows.push_back(row_cfg(CFG_WINDOW_SIZE, 11'h7F0));
    rows.push_back(row_cfg(CFG_PLANE_WIDTH, 11'd0));
    rows.push_back(row_cfg(CFG_PLANE_HEIGHT, 11'd0));
    rows.push_back(row_mean(16'h7FFF, 16'h7FFF, 1'b1, 1'b1));
    rows.push_back(row_mean(16'h8000, 16'h8000, 1'b1, 1'b1));
    rows.push_back(row_mean(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    rows.push_back(row_cfg(CFG_UNUSED_IDX, 11'h2AA));
    rows.push_back(row_mean(16'h0001, 16'h0001, 1'b1, 1'b1));
    // 2x2 window over a 2x2 plane: extremes, then a negative sum truncated to zero
    rows.push_back(row_cfg(CFG_WINDOW_SIZE, 11'd2));
    rows.push_back(row_cfg(CFG_PLANE_WIDTH, 11'd2));
    rows.push_back(row_cfg(CFG_PLANE_HEIGHT, 11'd2));
    repeat (3) rows.push_back(row_smp(16'h8000));
    rows.push_back(row_mean(16'h8000, 16'h8000, 1'b1, 1'b1));
    repeat (3) rows.push_back(row_smp(16'h7FFF));
    rows.push_back(row_mean(16'h7FFF, 16'h7FFF, 1'b1, 1'b1));
    repeat (3) rows.push_back(row_smp(16'hFFFF));
    rows.push_back(row_mean(16'h0000, 16'h0000, 1'b1, 1'b1));
    // oversize window saturates to 8; a 4x4 plane holds no window
    rows.push_back(row_cfg(CFG_WINDOW_SIZE, 11'h00F));
    rows.push_back(row_cfg(CFG_PLANE_WIDTH, 11'd4));
    rows.push_back(row_cfg(CFG_PLANE_HEIGHT, 11'd4));
    rows.push_back(row_smp(16'h4000));
    rows.push_back(row_smp(16'hC000));
    // 3x2 plane, window 2: trailing column dropped
    rows.push_back(row_cfg(CFG_WINDOW_SIZE, 11'd2));
    rows.push_back(row_cfg(CFG_PLANE_WIDTH, 11'd3));
    rows.push_back(row_cfg(CFG_PLANE_HEIGHT, 11'd2));
    rows.push_back(row_smp(16'h0100));
    rows.push_back(row_smp(16'h0200));
    rows.push_back(row_smp(16'h7FFF));
    rows.push_back(row_smp(16'hFF00));
    rows.push_back(row_smp(16'h0300));
    rows.push_back(row_smp(16'h8000));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk; config batches only once the block is quiet
    in_cfg = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        if (!in_cfg) settle();
        cfg_write(rows[i].idx, rows[i].val);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        send_sample(rows[i].smp, rows[i].typed, rows[i].want);
      end
    end

    // random phases: new geometry in every phase but one, mostly small planes with whole windows
    rand_items = 0;
    phase      = 0;
    while (rand_items < RANDOM_ITEMS) begin
      settle();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // sender paused until drained; stream resumes mid-plane, no writes
        n = $urandom_range(10, 40);
      end else begin
        if (phase == 1) begin
          // every sample is a mean: long receiver hold backs up into the input
          kv = 1;
          wv = 1;
          hv = 1;
          tx_calm = 1'b1;
        end else begin
          case ($urandom_range(0, 9))
            0:       kv = 0;
            1:       kv = 15;
            2:       kv = 8;
            3, 4:    kv = 1;
            default: kv = $urandom_range(2, 4);
          endcase
          ke = clamp_dim(kv, MAX_WINDOW);
          wv = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 24) : ke * $urandom_range(1, 3);
          hv = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : ke * $urandom_range(1, 2);
        end
        we = clamp_dim(wv, MAX_WIDTH);
        he = clamp_dim(hv, MAX_WIDTH);
        start = $urandom_range(0, 2);
        for (int j = 0; j < 3; j++) begin
          idx = reg_order[(start + j) % 3];
          case (idx)
            CFG_WINDOW_SIZE: val = {7'($urandom()), 4'(kv)};  // upper bits are don't-care
            CFG_PLANE_WIDTH: val = 11'(wv);
            default:         val = 11'(hv);
          endcase
          cfg_write(idx, val);
        end
        if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED_IDX, 11'($urandom()));
        cfg_we <= 1'b0;
        if (phase == 1) begin
          rx_long_hold = 1'b1;
          n = 40;
        end else begin
          n = we * he * $urandom_range(1, 2) + $urandom_range(0, we);
          if (n > 200) n = 200;
        end
      end
      if (n > RANDOM_ITEMS - rand_items) n = RANDOM_ITEMS - rand_items;
      for (int i = 0; i < n; i++) begin
        send_sample(rand_sample(), 1'b0, none);
        rand_items++;
      end
      phase++;
    end

    // closing part without idling: saturated width, then saturated height
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    settle();
    cfg_write(CFG_WINDOW_SIZE, 11'd1);
    cfg_write(CFG_PLANE_WIDTH, 11'h7FF);
    cfg_write(CFG_PLANE_HEIGHT, 11'd1);
    cfg_we <= 1'b0;
    repeat (BIG_RUN) send_sample(rand_sample(), 1'b0, none);
    settle();
    cfg_write(CFG_PLANE_WIDTH, 11'd1);
    cfg_write(CFG_PLANE_HEIGHT, 11'h7FF);
    cfg_we <= 1'b0;
    repeat (BIG_RUN) send_sample(rand_sample(), 1'b0, none);
    settle();

    if (n_errors == 0) begin
      $display("average_pool_forward regression: pass");
    end else begin
      $display("average_pool_forward regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/avgp_pkg.sv
rtl/avgp_front.sv
rtl/avgp_queue.sv
rtl/avgp_back.sv
rtl/average_pool_forward.sv
dv/tb_top.sv
